### sv/ssdr_pkg.sv
// Package: shared types, constants and codes of the scanline span depth resolve block.
package ssdr_pkg;

   // Default line width in pixels
   localparam int LINE_WIDTH_DEF = 1024;

   // Field widths fixed by the command format
   localparam int XIN_W   = 11;
   localparam int PX_W    = 10;
   localparam int DEPTH_W = 32;
   localparam int COLOR_W = 32;
   localparam int WON_W   = 11;
   localparam int CMD_W   = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Depth limits, signed Q16.16
   localparam logic [DEPTH_W-1:0] DEPTH_MIN = 32'h8000_0000;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = 32'h7FFF_FFFF;

   // Request payload
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [XIN_W-1:0]   left_x;
      logic [XIN_W-1:0]   right_x;
      logic [DEPTH_W-1:0] start_depth;
      logic [DEPTH_W-1:0] depth_step;
      logic [COLOR_W-1:0] span_color;
      logic [PX_W-1:0]    pixel_x;
   } req_payload_type;

   // Response payload
   typedef struct packed {
      logic [WON_W-1:0]   pixels_won;
      logic [COLOR_W-1:0] pixel_color;
      logic               pixel_written;
   } rsp_payload_type;

   // One entry of the depth line: written mark and stored depth
   typedef struct packed {
      logic               mark;
      logic [DEPTH_W-1:0] depth;
   } depth_entry_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_DRAW,
      ST_READ,
      ST_READ_WAIT,
      ST_FINISH
   } ssdr_state_type;

endpackage

### sv/ssdr_req_if.sv
// Interface: request channel carrying one command per transfer.
interface ssdr_req_if;
   import ssdr_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### sv/ssdr_rsp_if.sv
// Interface: response channel carrying one result per transfer.
interface ssdr_rsp_if;
   import ssdr_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### sv/scanline_span_depth_resolve.sv
// Top level: one-scanline depth buffer and colour line with clear, draw span and read.
//
//   channel    direction  transfer when            carries
//   req_chan   in         valid & ready            cmd, span ends, depth, step, colour, pixel
//   rsp_chan   out        valid & ready            pixels won, pixel colour, written mark
//
// Clear writes one depth-line entry per cycle, driven by the sweep counter. In a draw the
// depth-line read port, the depth comparator and the saturating adder handle one pixel per
// cycle, with the read of pixel x+1 overlapping the write of pixel x. A read passes through
// the read and read-wait states; an unknown command goes straight to the finish state.
// After reset the same sweep clears the whole line; req_chan.ready stays low meanwhile.
// req_chan.ready is high only when the sequencer is idle; a finished result waits in the
// sequencer while the response register is still held by a stalled sink.
module scanline_span_depth_resolve #(
   parameter int LINE_WIDTH = ssdr_pkg::LINE_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ssdr_req_if.sink   req_chan,
   ssdr_rsp_if.source rsp_chan
);
   import ssdr_pkg::*;

   localparam int AW = $clog2(LINE_WIDTH);
   localparam int CW = (AW + 1 > XIN_W) ? AW + 1 : XIN_W;
   localparam logic [CW-1:0] LW_C   = CW'(LINE_WIDTH);
   localparam logic [CW-1:0] LAST_C = CW'(LINE_WIDTH - 1);

   // Memories
   depth_entry_type    depth_mem [LINE_WIDTH];
   logic [COLOR_W-1:0] color_mem [LINE_WIDTH];

   // Sequencer and datapath registers
   ssdr_state_type     state_ff, state_in;
   logic [CW-1:0]      x_ff, x_in;
   logic [CW-1:0]      end_ff, end_in;
   logic [DEPTH_W-1:0] z_ff, z_in;
   logic [DEPTH_W-1:0] dz_ff, dz_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [PX_W-1:0]    px_ff, px_in;
   logic               p_valid_ff, p_valid_in;
   logic [AW-1:0]      p_x_ff, p_x_in;
   logic [DEPTH_W-1:0] p_z_ff, p_z_in;
   logic [WON_W-1:0]   res_won_ff, res_won_in;
   logic [COLOR_W-1:0] res_color_ff, res_color_in;
   logic               res_written_ff, res_written_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;
   depth_entry_type    rd_entry_ff;
   logic [COLOR_W-1:0] rd_color_ff;

   // Combinational control
   logic               req_xfer;
   logic               rsp_free;
   logic               issue;
   logic               win;
   logic [DEPTH_W:0]   z_sum;
   logic [DEPTH_W-1:0] z_sat;
   logic [CW-1:0]      rx_ext;
   logic [CW-1:0]      px_ext;
   logic               px_in_line;
   logic [AW-1:0]      rd_addr;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   depth_entry_type    mem_wentry;
   logic               color_we;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Span issue, depth test and saturating depth step
   assign issue = (state_ff == ST_DRAW) && (x_ff < end_ff);
   assign win   = p_valid_ff && ($signed(p_z_ff) > $signed(rd_entry_ff.depth));
   assign z_sum = {z_ff[DEPTH_W-1], z_ff} + {dz_ff[DEPTH_W-1], dz_ff};

   always_comb begin
      if (z_sum[DEPTH_W] != z_sum[DEPTH_W-1]) begin
         z_sat = z_sum[DEPTH_W] ? DEPTH_MIN : DEPTH_MAX;
      end else begin
         z_sat = z_sum[DEPTH_W-1:0];
      end
   end

   assign rx_ext     = CW'(req_chan.data.right_x);
   assign px_ext     = CW'(px_ff);
   assign px_in_line = (px_ext < LW_C);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (x_ff == LAST_C) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_chan.data.cmd)
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_DRAW:  state_in = ST_DRAW;
                  CMD_READ:  state_in = ST_READ;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_CLEAR: begin
            if (x_ff == LAST_C) state_in = ST_FINISH;
         end
         ST_DRAW: begin
            if (!issue && !p_valid_ff) state_in = ST_FINISH;
         end
         ST_READ:      state_in = ST_READ_WAIT;
         ST_READ_WAIT: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_INIT;
      endcase
   end

   // Memory port control
   always_comb begin
      mem_we     = 1'b0;
      mem_waddr  = x_ff[AW-1:0];
      mem_wentry = '{mark: 1'b0, depth: DEPTH_MIN};
      color_we   = 1'b0;
      rd_addr    = px_ext[AW-1:0];
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_DRAW: begin
            rd_addr    = x_ff[AW-1:0];
            mem_we     = win;
            color_we   = win;
            mem_waddr  = p_x_ff;
            mem_wentry = '{mark: 1'b1, depth: p_z_ff};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      x_in           = x_ff;
      end_in         = end_ff;
      z_in           = z_ff;
      dz_in          = dz_ff;
      color_in       = color_ff;
      px_in          = px_ff;
      p_valid_in     = issue;
      p_x_in         = x_ff[AW-1:0];
      p_z_in         = z_ff;
      res_won_in     = res_won_ff;
      res_color_in   = res_color_ff;
      res_written_in = res_written_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in    = rsp_data_ff;
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            x_in = x_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_xfer) begin
               // Latch the command and start from an all-zero result
               x_in           = (req_chan.data.cmd == CMD_DRAW) ?
                                CW'(req_chan.data.left_x) : '0;
               end_in         = (rx_ext > LW_C) ? LW_C : rx_ext;
               z_in           = req_chan.data.start_depth;
               dz_in          = req_chan.data.depth_step;
               color_in       = req_chan.data.span_color;
               px_in          = req_chan.data.pixel_x;
               res_won_in     = '0;
               res_color_in   = '0;
               res_written_in = 1'b0;
            end
         end
         ST_DRAW: begin
            // Advance the span walk and count each winning pixel
            if (issue) begin
               x_in = x_ff + 1'b1;
               z_in = z_sat;
            end
            if (win) res_won_in = res_won_ff + 1'b1;
         end
         ST_READ_WAIT: begin
            if (px_in_line) begin
               res_color_in   = rd_color_ff;
               res_written_in = rd_entry_ff.mark;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{pixels_won: res_won_ff, pixel_color: res_color_ff,
                                pixel_written: res_written_ff};
            end
         end
         default: begin
            p_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         x_ff         <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      end_ff         <= end_in;
      z_ff           <= z_in;
      dz_ff          <= dz_in;
      color_ff       <= color_in;
      px_ff          <= px_in;
      p_x_ff         <= p_x_in;
      p_z_ff         <= p_z_in;
      res_won_ff     <= res_won_in;
      res_color_ff   <= res_color_in;
      res_written_ff <= res_written_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Depth line: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) depth_mem[mem_waddr] <= mem_wentry;
      rd_entry_ff <= depth_mem[rd_addr];
   end

   // Colour line: written only by winning pixels
   always_ff @(posedge clock) begin
      if (color_we) color_mem[p_x_ff] <= color_ff;
      rd_color_ff <= color_mem[rd_addr];
   end

   // A pixel in the compare stage was issued by the span walk
   a_pipe_from_draw: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> $past(state_ff) == ST_DRAW)
      else $error("compare stage loaded outside a span walk");

   // A winning write lands inside the clamped span
   a_win_in_span: assert property (@(posedge clock) disable iff (reset)
      win |-> CW'(p_x_ff) < end_ff)
      else $error("depth write beyond the span end");

   // A new response appears only out of the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside finish");

   // The reset sweep never produces a response
   a_init_silent: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INIT |-> !rsp_valid_ff)
      else $error("response pending during reset sweep");

endmodule
